[rtl/core/tcr_pkg.sv]
// Package: shared types, codes and constants of the text console renderer.
`timescale 1ns / 1ps
package tcr_pkg;

  // Default geometry of the screen.
  localparam int unsigned ROW_COUNT_DEF = 25;
  localparam int unsigned COL_COUNT_DEF = 80;
  localparam int unsigned TAB_STOP_DEF  = 8;

  // Field widths of the request and result channels.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CR_NL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_BS        = 8'h08;
  localparam char_t CH_TAB       = 8'h09;
  localparam char_t CH_CR        = 8'h0D;
  localparam char_t CH_LF        = 8'h0A;
  localparam char_t CH_SPACE     = 8'h20;
  localparam char_t CH_GLYPH_RST = 8'h7C;

endpackage

[rtl/core/tcr_if.sv]
// Interfaces: request and result channels of the text console renderer.
`timescale 1ns / 1ps
interface tcr_in_if;
  import tcr_pkg::*;

  logic              valid;
  logic              ready;
  op_t               operation;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output operation, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input operation, input char_code, input cell_index,
                  output ready);
endinterface

interface tcr_out_if;
  import tcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] read_data;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic              scrolled;

  modport source (output valid, output read_data, output cursor_row, output cursor_col,
                  output scrolled, input ready);
  modport sink   (input valid, input read_data, input cursor_row, input cursor_col,
                  input scrolled, output ready);
endinterface

[rtl/core/tcr_fbuf.sv]
// Frame buffer memory: one write port and one registered read port.
`timescale 1ns / 1ps
module tcr_fbuf #(
  parameter int unsigned DEPTH = tcr_pkg::ROW_COUNT_DEF * tcr_pkg::COL_COUNT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tcr_pkg::CHAR_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tcr_pkg::CHAR_W-1:0] rdata
);
  import tcr_pkg::*;

  char_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/text_console_character_renderer.sv]
// Top level: text console with a character frame buffer and a software cursor.
`timescale 1ns / 1ps
// The console takes one request at a time and is not ready while it works.
// A put passes through the calculate, character, erase and draw states, a
// read through the read and read-data states; every cell access goes through
// the single write port and single read port of the frame buffer, and the
// cursor's cell address comes from one shared row-times-width multiply-add
// unit. A put that runs past the last row scrolls the screen: every cell
// below the top line is moved up one line and the bottom line is blanked.
// A clear request writes every cell with a space. After reset the same
// clearing pass runs before the first request is taken; configuration
// writes are accepted at any time.
module text_console_character_renderer #(
  parameter int unsigned ROW_COUNT = tcr_pkg::ROW_COUNT_DEF,
  parameter int unsigned COL_COUNT = tcr_pkg::COL_COUNT_DEF,
  parameter int unsigned TAB_STOP  = tcr_pkg::TAB_STOP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tcr_in_if.sink                        in_chan,
  tcr_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcr_pkg::*;

  localparam int unsigned CELLS = ROW_COUNT * COL_COUNT;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned RW    = $clog2(ROW_COUNT + 1);
  localparam int unsigned CLW   = $clog2(COL_COUNT);
  localparam int unsigned COLW  = $clog2(COL_COUNT + TAB_STOP);
  localparam int unsigned PW    = $clog2(TAB_STOP);
  localparam int unsigned IXW   = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CALC  = 10'b00_0000_0010,
    S_CHAR  = 10'b00_0000_0100,
    S_COPY  = 10'b00_0000_1000,
    S_FILL  = 10'b00_0001_0000,
    S_ERASE = 10'b00_0010_0000,
    S_DRAW  = 10'b00_0100_0000,
    S_READ  = 10'b00_1000_0000,
    S_RDATA = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Control state.
  logic            boot_r, boot_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CLW-1:0]  col_r, col_nxt;
  logic [PW-1:0]   ph_r, ph_nxt;
  logic [AW-1:0]   last_r, last_nxt;
  logic            erase_r, erase_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            wv_r, wv_nxt;
  logic            cr_nl_r;
  char_t           glyph_r;
  logic            out_valid_r, out_valid_nxt;

  // Payload registers.
  op_t             op_r;
  char_t           ch_r;
  logic [IDX_W-1:0] idx_r;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   wa_r, wa_nxt;
  logic            scr_r, scr_nxt;
  char_t           rd_r, rd_nxt;
  char_t           out_rd_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic            out_scr_r;

  // Frame buffer ports.
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  char_t           mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  char_t           mem_rdata;

  // Shared address unit: cell index of the current cursor position.
  logic [CW-1:0]   mul_prod;
  logic [AW-1:0]   cell_addr;

  logic [COLW-1:0] col_mv;
  logic [RW-1:0]   row_mv;
  logic [PW-1:0]   ph_mv;
  logic            printable;
  logic            idx_ok;

  assign mul_prod  = CW'(row_r) * CW'(COL_COUNT) + CW'(col_r);
  assign cell_addr = mul_prod[AW-1:0];
  assign printable = (ch_r >= CH_SPACE) && !ch_r[CHAR_W-1];
  assign idx_ok    = IXW'(idx_r) < IXW'(CELLS);

  tcr_fbuf #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_fbuf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Cursor motion for a put request, including the wrap to the next row.
  always_comb begin
    col_mv = COLW'(col_r);
    row_mv = row_r;
    ph_mv  = ph_r;
    unique case (ch_r)
      CH_BS: begin
        if (col_r != '0) begin
          col_mv = COLW'(col_r) - COLW'(1);
          ph_mv  = (ph_r == '0) ? PW'(TAB_STOP - 1) : ph_r - PW'(1);
        end
      end
      CH_TAB: begin
        col_mv = COLW'(col_r) - COLW'(ph_r) + COLW'(TAB_STOP);
        ph_mv  = '0;
      end
      CH_CR: begin
        col_mv = '0;
        ph_mv  = '0;
        if (cr_nl_r) begin
          row_mv = row_r + RW'(1);
        end
      end
      CH_LF: begin
        col_mv = '0;
        ph_mv  = '0;
        row_mv = row_r + RW'(1);
      end
      default: begin
        if (printable) begin
          col_mv = COLW'(col_r) + COLW'(1);
          ph_mv  = (ph_r == PW'(TAB_STOP - 1)) ? '0 : ph_r + PW'(1);
        end
      end
    endcase
    if (col_mv >= COLW'(COL_COUNT)) begin
      col_mv = '0;
      ph_mv  = '0;
      row_mv = row_mv + RW'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    boot_nxt      = boot_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ph_nxt        = ph_r;
    last_nxt      = last_r;
    erase_nxt     = erase_r;
    cnt_nxt       = cnt_r;
    wv_nxt        = wv_r;
    out_valid_nxt = out_valid_r;
    addr_nxt      = addr_r;
    wa_nxt        = wa_r;
    scr_nxt       = scr_r;
    rd_nxt        = rd_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = CH_SPACE;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r[AW-1:0];

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          scr_nxt = 1'b0;
          rd_nxt  = '0;
          unique case (in_chan.operation)
            OP_PUT:   state_nxt = S_CALC;
            OP_READ:  state_nxt = S_READ;
            OP_CLEAR: begin
              erase_nxt = 1'b1;
              row_nxt   = '0;
              col_nxt   = '0;
              ph_nxt    = '0;
              cnt_nxt   = '0;
              state_nxt = S_FILL;
            end
            OP_NOP:   state_nxt = S_DONE;
            default:  state_nxt = S_DONE;
          endcase
        end
      end

      S_CALC: begin
        // The shared unit still sees the old cursor: this is the write position.
        addr_nxt = cell_addr;
        row_nxt  = row_mv;
        col_nxt  = CLW'(col_mv);
        ph_nxt   = ph_mv;
        if (ch_r == CH_BS || ch_r == CH_TAB || ch_r == CH_CR || ch_r == CH_LF) begin
          erase_nxt = 1'b1;
        end
        state_nxt = S_CHAR;
      end

      S_CHAR: begin
        if (printable) begin
          mem_we    = 1'b1;
          mem_waddr = addr_r;
          mem_wdata = ch_r;
        end
        if (row_r == RW'(ROW_COUNT)) begin
          scr_nxt   = 1'b1;
          row_nxt   = RW'(ROW_COUNT - 1);
          erase_nxt = 1'b1;
          if (last_r >= AW'(COL_COUNT)) begin
            last_nxt = last_r - AW'(COL_COUNT);
          end else begin
            last_nxt = last_r + AW'(CELLS - COL_COUNT);
          end
          cnt_nxt   = CW'(COL_COUNT);
          wv_nxt    = 1'b0;
          state_nxt = S_COPY;
        end else begin
          state_nxt = S_ERASE;
        end
      end

      S_COPY: begin
        // Read one line below, write the cell read in the previous cycle.
        if (wv_r) begin
          mem_we    = 1'b1;
          mem_waddr = wa_r;
          mem_wdata = mem_rdata;
        end
        if (cnt_r == CW'(CELLS)) begin
          wv_nxt    = 1'b0;
          cnt_nxt   = CW'(CELLS - COL_COUNT);
          state_nxt = S_FILL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r[AW-1:0];
          wa_nxt    = cnt_r[AW-1:0] - AW'(COL_COUNT);
          wv_nxt    = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
        end
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = CH_SPACE;
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == CW'(CELLS - 1)) begin
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ERASE;
          end
        end
      end

      S_ERASE: begin
        if (erase_r) begin
          mem_we    = 1'b1;
          mem_waddr = last_r;
          mem_wdata = CH_SPACE;
        end
        addr_nxt  = cell_addr;
        state_nxt = S_DRAW;
      end

      S_DRAW: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = glyph_r;
        erase_nxt = 1'b0;
        last_nxt  = addr_r;
        state_nxt = S_DONE;
      end

      S_READ: begin
        mem_re    = idx_ok;
        mem_raddr = AW'(idx_r);
        state_nxt = S_RDATA;
      end

      S_RDATA: begin
        rd_nxt    = idx_ok ? mem_rdata : '0;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      boot_r      <= 1'b1;
      row_r       <= '0;
      col_r       <= '0;
      ph_r        <= '0;
      last_r      <= '0;
      erase_r     <= 1'b0;
      cnt_r       <= '0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      ph_r        <= ph_nxt;
      last_r      <= last_nxt;
      erase_r     <= erase_nxt;
      cnt_r       <= cnt_nxt;
      wv_r        <= wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_nl_r <= 1'b1;
      glyph_r <= CH_GLYPH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CR_NL: cr_nl_r <= cfg_data[0];
        CFG_GLYPH: glyph_r <= cfg_data[CHAR_W-1:0];
        default:   glyph_r <= glyph_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_chan.valid) begin
      op_r  <= in_chan.operation;
      ch_r  <= in_chan.char_code;
      idx_r <= in_chan.cell_index;
    end
    addr_r <= addr_nxt;
    wa_r   <= wa_nxt;
    scr_r  <= scr_nxt;
    rd_r   <= rd_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_chan.ready)) begin
      out_rd_r  <= (op_r == OP_READ) ? rd_r : '0;
      out_row_r <= ROW_W'(row_r);
      out_col_r <= COL_W'(col_r);
      out_scr_r <= scr_r;
    end
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.read_data  = out_rd_r;
  assign out_chan.cursor_row = out_row_r;
  assign out_chan.cursor_col = out_col_r;
  assign out_chan.scrolled   = out_scr_r;

endmodule
